/* rtl/core/ttss_pkg.sv */
`default_nettype none

package ttss_pkg;

	// Default number of task slots in the table.
	localparam int DEFAULT_SLOT_COUNT = 16;

	// Operation carried by an input word.
	typedef enum logic [3:0] {
		MODE_TICK       = 4'd0,
		MODE_STEP       = 4'd1,
		MODE_ADD        = 4'd2,
		MODE_REMOVE     = 4'd3,
		MODE_SUSPEND    = 4'd4,
		MODE_RESUME     = 4'd5,
		MODE_TRIGGER    = 4'd6,
		MODE_RESCHEDULE = 4'd7,
		MODE_SET_PERIOD = 4'd8
	} item_mode_t;

	// Kind of task requested by an add.
	typedef enum logic [2:0] {
		KIND_CYCLIC    = 3'd0,
		KIND_SUSPENDED = 3'd1,
		KIND_TRIG_IDLE = 3'd2,
		KIND_SHOT_TIME = 3'd3,
		KIND_SHOT_NOW  = 3'd4
	} add_kind_t;

	// Mode stored in a slot.
	typedef enum logic [2:0] {
		SM_IDLE      = 3'd0,
		SM_CYCLIC    = 3'd1,
		SM_TRIGGER   = 3'd2,
		SM_SHOT_TIME = 3'd3,
		SM_DELETE    = 3'd4
	} slot_mode_t;

	// One entry of the slot memory.
	typedef struct packed {
		slot_mode_t  mode;
		logic [31:0] period;
		logic [31:0] count;
	} slot_entry_t;

	// One result word.
	typedef struct packed {
		logic       fired;
		logic [3:0] fired_slot;
		logic       scan_done;
		logic       shortage;
		logic       add_ok;
		logic [3:0] added_slot;
	} result_t;

	// Sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

`default_nettype wire

/* rtl/core/tick_task_slot_scheduler.sv */
// Channel  | Handshake                    | Payload
// ---------+------------------------------+-----------------------------------------------
// input    | in_valid / in_ready          | mode, slot, period, add_kind
// output   | out_valid / out_ready        | fired, fired_slot, scan_done, shortage,
//          |                              | add_ok, added_slot
//
// Each input word takes two steps: the registered read of the slot memory, then the
// update and write-back of the entry. No new word is taken until the update is done, and
// the update waits while the output register still holds an untaken word.
// Reset clears the used bits and the scan state at once; a free slot reads as empty, so
// the slot memory needs no clearing pass.
`default_nettype none

module tick_task_slot_scheduler #(
	parameter int SLOT_COUNT = ttss_pkg::DEFAULT_SLOT_COUNT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  mode,
	input  wire logic [3:0]  slot,
	input  wire logic [31:0] period,
	input  wire logic [2:0]  add_kind,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             fired,
	output logic [3:0]       fired_slot,
	output logic             scan_done,
	output logic             shortage,
	output logic             add_ok,
	output logic [3:0]       added_slot
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int POS_W = $clog2(SLOT_COUNT + 1);
	localparam int CMP_W = (POS_W > 4) ? POS_W : 4;

	// Slot memory and its registered read port.
	ttss_pkg::slot_entry_t mem [SLOT_COUNT];
	ttss_pkg::slot_entry_t rd_data_q;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_raddr;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	ttss_pkg::slot_entry_t mem_wdata;

	// Control state.
	ttss_pkg::state_t      state_q, state_d;
	logic [SLOT_COUNT-1:0] used_q, used_d;
	logic [POS_W-1:0]      pos_q, pos_d;
	logic                  pending_q, pending_d;
	logic                  guard_q, guard_d;

	// Captured input word.
	logic [3:0]       mode_q;
	logic [3:0]       slot_q;
	logic [31:0]      period_q;
	logic [2:0]       kind_q;
	logic [IDX_W-1:0] addr_q;
	logic             free_any_q;

	// Output register.
	logic                out_valid_q;
	ttss_pkg::result_t   res_q, res_d;
	logic                load_out;

	// Lowest free slot: isolate the lowest set bit of the free vector, then encode it.
	logic [SLOT_COUNT-1:0] free_vec;
	logic [SLOT_COUNT-1:0] free_hot;
	logic [IDX_W-1:0]      free_idx;
	logic                  free_any;

	assign free_vec = ~used_q;
	assign free_hot = free_vec & (~free_vec + SLOT_COUNT'(1));
	assign free_any = |free_vec;

	always_comb begin
		free_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (free_hot[i]) begin
				free_idx = free_idx | IDX_W'(i);
			end
		end
	end

	// Address of the entry that an input word works on.
	logic [CMP_W-1:0] in_slot_ext;
	logic             pos_in_range;
	logic [IDX_W-1:0] accept_addr;

	assign in_slot_ext  = CMP_W'(slot);
	assign pos_in_range = pos_q < POS_W'(SLOT_COUNT);

	always_comb begin
		priority case (1'b1)
			mode == ttss_pkg::MODE_STEP: accept_addr = pos_in_range ? pos_q[IDX_W-1:0] : '0;
			mode == ttss_pkg::MODE_ADD:  accept_addr = free_idx;
			default:                     accept_addr = in_slot_ext[IDX_W-1:0];
		endcase
	end

	// Values used during the update cycle.
	logic        slot_ok;
	logic        live;
	logic        editable;
	logic        same_pos;
	logic [31:0] cnt_inc;

	assign slot_ok  = 32'(slot_q) < 32'(SLOT_COUNT);
	assign live     = slot_ok && used_q[addr_q];
	assign editable = live && (rd_data_q.mode != ttss_pkg::SM_DELETE);
	assign same_pos = CMP_W'(slot_q) == CMP_W'(pos_q);
	assign cnt_inc  = (rd_data_q.count == 32'hFFFF_FFFF) ? rd_data_q.count
		: rd_data_q.count + 32'd1;

	assign in_ready = (state_q == ttss_pkg::ST_IDLE);

	// Next state, table update and result.
	always_comb begin
		state_d   = state_q;
		used_d    = used_q;
		pos_d     = pos_q;
		pending_d = pending_q;
		guard_d   = guard_q;
		mem_re    = 1'b0;
		mem_raddr = accept_addr;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = rd_data_q;
		res_d     = '0;
		load_out  = 1'b0;

		unique case (state_q)
			ttss_pkg::ST_IDLE: begin
				if (in_valid) begin
					mem_re  = 1'b1;
					state_d = ttss_pkg::ST_EXEC;
				end
			end
			ttss_pkg::ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ttss_pkg::ST_IDLE;
					unique case (ttss_pkg::item_mode_t'(mode_q))
						ttss_pkg::MODE_TICK: begin
							pending_d = 1'b1;
							guard_d   = 1'b1;
						end
						ttss_pkg::MODE_STEP: begin
							if (pending_q) begin
								if (!pos_in_range) begin
									// The scan has passed the last slot.
									res_d.scan_done = 1'b1;
									res_d.shortage  = guard_q;
									pos_d           = '0;
									pending_d       = 1'b0;
									guard_d         = 1'b0;
								end else begin
									pos_d = pos_q + POS_W'(1);
									if (used_q[addr_q]) begin
										if (rd_data_q.mode == ttss_pkg::SM_DELETE) begin
											used_d[addr_q] = 1'b0;
										end else if (rd_data_q.period != 32'd0 &&
											(rd_data_q.mode == ttss_pkg::SM_CYCLIC ||
											rd_data_q.mode == ttss_pkg::SM_SHOT_TIME)) begin
											mem_we = 1'b1;
											if (cnt_inc >= rd_data_q.period) begin
												mem_wdata.count  = '0;
												res_d.fired      = 1'b1;
												res_d.fired_slot = 4'(addr_q);
												if (rd_data_q.mode == ttss_pkg::SM_SHOT_TIME) begin
													used_d[addr_q] = 1'b0;
												end
											end else begin
												mem_wdata.count = cnt_inc;
											end
										end else if (rd_data_q.mode == ttss_pkg::SM_TRIGGER) begin
											res_d.fired      = 1'b1;
											res_d.fired_slot = 4'(addr_q);
											used_d[addr_q]   = 1'b0;
										end
									end
								end
							end
						end
						ttss_pkg::MODE_ADD: begin
							if (kind_q <= ttss_pkg::KIND_SHOT_NOW && free_any_q) begin
								used_d[addr_q]   = 1'b1;
								mem_we           = 1'b1;
								mem_wdata.count  = '0;
								mem_wdata.period = period_q;
								mem_wdata.mode   = ttss_pkg::SM_IDLE;
								res_d.add_ok     = 1'b1;
								res_d.added_slot = 4'(addr_q);
								unique case (ttss_pkg::add_kind_t'(kind_q))
									ttss_pkg::KIND_CYCLIC: begin
										mem_wdata.mode = ttss_pkg::SM_CYCLIC;
									end
									ttss_pkg::KIND_TRIG_IDLE: begin
										mem_wdata.period = '0;
									end
									ttss_pkg::KIND_SHOT_TIME: begin
										mem_wdata.mode = ttss_pkg::SM_SHOT_TIME;
									end
									ttss_pkg::KIND_SHOT_NOW: begin
										mem_wdata.period = '0;
										mem_wdata.mode   = ttss_pkg::SM_TRIGGER;
										pending_d        = 1'b1;
									end
									default: begin
									end
								endcase
							end
						end
						ttss_pkg::MODE_REMOVE: begin
							// A slot under the scan is only marked; the scan frees it.
							if (slot_ok) begin
								if (live && same_pos) begin
									mem_we         = 1'b1;
									mem_wdata.mode = ttss_pkg::SM_DELETE;
								end else begin
									used_d[addr_q] = 1'b0;
								end
							end
						end
						ttss_pkg::MODE_SUSPEND: begin
							if (editable) begin
								mem_we         = 1'b1;
								mem_wdata.mode = ttss_pkg::SM_IDLE;
							end
						end
						ttss_pkg::MODE_RESUME: begin
							if (editable) begin
								mem_we         = 1'b1;
								mem_wdata.mode = ttss_pkg::SM_CYCLIC;
							end
						end
						ttss_pkg::MODE_TRIGGER: begin
							if (editable) begin
								mem_we         = 1'b1;
								mem_wdata.mode = ttss_pkg::SM_TRIGGER;
								pending_d      = 1'b1;
							end
						end
						ttss_pkg::MODE_RESCHEDULE: begin
							if (live) begin
								mem_we          = 1'b1;
								mem_wdata.count = rd_data_q.period;
							end
						end
						ttss_pkg::MODE_SET_PERIOD: begin
							if (live) begin
								mem_we           = 1'b1;
								mem_wdata.period = period_q;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = ttss_pkg::ST_IDLE;
			end
		endcase
	end

	// Slot memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	// Captured input word.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q     <= mode;
			slot_q     <= slot;
			period_q   <= period;
			kind_q     <= add_kind;
			addr_q     <= accept_addr;
			free_any_q <= free_any;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q <= res_d;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ttss_pkg::ST_IDLE;
			used_q      <= '0;
			pos_q       <= '0;
			pending_q   <= 1'b0;
			guard_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			used_q    <= used_d;
			pos_q     <= pos_d;
			pending_q <= pending_d;
			guard_q   <= guard_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign fired      = res_q.fired;
	assign fired_slot = res_q.fired_slot;
	assign scan_done  = res_q.scan_done;
	assign shortage   = res_q.shortage;
	assign add_ok     = res_q.add_ok;
	assign added_slot = res_q.added_slot;

endmodule

`default_nettype wire

/* rtl/core/ttss_checker.sv */
`default_nettype none

module ttss_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       fired,
	input wire logic [3:0] fired_slot,
	input wire logic       scan_done,
	input wire logic       shortage,
	input wire logic       add_ok,
	input wire logic [3:0] added_slot
);

	// A word reports at most one kind of event.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(fired && scan_done) && !(fired && add_ok) && !(scan_done && add_ok))
	else $error("result word reports more than one event");

	// A shortage is only reported at the end of a scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && shortage |-> scan_done)
	else $error("shortage reported outside a scan end");

	// Slot indexes are zero when their event flag is clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fired || fired_slot == 4'd0) && (add_ok || added_slot == 4'd0))
	else $error("slot index set without its event");

	// A stalled result word holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({fired, fired_slot, scan_done,
			shortage, add_ok, added_slot}))
	else $error("stalled result word changed");

endmodule

bind tick_task_slot_scheduler ttss_checker u_ttss_checker (.*);

`default_nettype wire
